// ===== rtl/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants for the fixed-point matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int VAL_W     = 16;
    localparam int PROD_W    = 32;
    localparam int PV_W      = 35;
    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_DIM_DEFAULT = 8;

    typedef enum logic [1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2
    } mm_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A = 2'd0,
        CFG_COLS_A = 2'd1,
        CFG_ROWS_B = 2'd2,
        CFG_COLS_B = 2'd3
    } mm_cfg_idx_t;

    typedef struct packed {
        logic             first;
        logic             endk;
        logic             last;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } mm_tag_t;

endpackage

// ===== rtl/mm_if.sv =====
// ----------------------------------------------------------------------------
// mm_if
// Request, response and configuration channels of the matrix multiply block.
// ----------------------------------------------------------------------------
interface mm_req_if;
    import mm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output cmd, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input cmd, input row, input col, input value,
                    output ready);
endinterface

interface mm_rsp_if;
    import mm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [IDX_W-1:0]       out_row;
    logic [IDX_W-1:0]       out_col;
    logic signed [PV_W-1:0] product_value;
    logic                   dim_error;
    logic                   last;

    modport source (output valid, output out_row, output out_col, output product_value,
                    output dim_error, output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input product_value,
                    input dim_error, input last, output ready);
endinterface

interface mm_cfg_if;
    import mm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mm_mac.sv =====
// ----------------------------------------------------------------------------
// mm_mac
// Shared multiply-accumulate unit: registered multiply, then exact accumulate.
// ----------------------------------------------------------------------------
module mm_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            op_valid,
    input  mm_pkg::mm_tag_t                 op_tag,
    input  logic signed [mm_pkg::VAL_W-1:0] op_a,
    input  logic signed [mm_pkg::VAL_W-1:0] op_b,
    output logic                            busy,
    output logic                            res_valid,
    output mm_pkg::mm_tag_t                 res_tag,
    output logic signed [mm_pkg::PV_W-1:0]  res_value
);
    import mm_pkg::*;

    logic                    prod_valid_reg;
    mm_tag_t                 prod_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PV_W-1:0]   acc_reg;
    logic signed [PV_W-1:0]   acc_base;
    logic signed [PV_W-1:0]   acc_next;

    assign acc_base = prod_tag_reg.first ? '0 : acc_reg;
    assign acc_next = acc_base + PV_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_tag_reg   <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
        end
        else if (adv)
        begin
            prod_valid_reg <= op_valid;
            prod_tag_reg   <= op_tag;
            prod_reg       <= op_a * op_b;
            if (prod_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign busy      = prod_valid_reg;
    assign res_valid = prod_valid_reg && prod_tag_reg.endk && adv;
    assign res_tag   = prod_tag_reg;
    assign res_value = acc_next;

endmodule

// ===== rtl/matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply
// Dense fixed-point matrix product C = A x B on one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// A write request stores one Q8.8 element of A or B. A compute request with
// matching inner dimensions streams every element of C in row-major order,
// last element marked, at one multiply-accumulate per cycle while the response
// side keeps up, set by the single shared multiplier and the one read port of
// each matrix memory. A mismatch gives one error response. The block takes no
// request while a compute is in flight. Matrix memories are not cleared at
// reset: read only elements that were written.
// ----------------------------------------------------------------------------
module matrix_multiply #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    mm_req_if.sink    req,
    mm_rsp_if.source  rsp,
    mm_cfg_if.sink    cfg
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_ERR
    } state_t;

    state_t state_reg;

    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] cols_a_reg;
    logic [DIM_W-1:0] rows_b_reg;
    logic [DIM_W-1:0] cols_b_reg;
    logic [DIM_W-1:0] ra;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cb;

    logic [DW-1:0] i_reg;
    logic [DW-1:0] j_reg;
    logic [DW-1:0] k_reg;
    logic          k_end;
    logic          j_end;
    logic          i_end;

    logic signed [VAL_W-1:0] mat_a [DEPTH];
    logic signed [VAL_W-1:0] mat_b [DEPTH];
    logic signed [VAL_W-1:0] rd_a_reg;
    logic signed [VAL_W-1:0] rd_b_reg;
    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic [AW-1:0]           waddr;
    logic                    in_range;
    logic                    req_fire;
    logic                    wr_a;
    logic                    wr_b;

    logic    op_valid_reg;
    mm_tag_t op_tag_reg;
    mm_tag_t issue_tag;
    logic    adv;
    logic    issue;
    logic    err_load;

    logic                   mac_busy;
    logic                   mac_res_valid;
    mm_tag_t                mac_res_tag;
    logic signed [PV_W-1:0] mac_res_value;

    logic                   rsp_valid_reg;
    logic [IDX_W-1:0]       out_row_reg;
    logic [IDX_W-1:0]       out_col_reg;
    logic signed [PV_W-1:0] product_value_reg;
    logic                   dim_error_reg;
    logic                   last_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    assign ra    = clamp_dim(rows_a_reg);
    assign inner = clamp_dim(cols_a_reg);
    assign cb    = clamp_dim(cols_b_reg);

    assign k_end = (DIM_W'(k_reg) + DIM_W'(1)) == inner;
    assign j_end = (DIM_W'(j_reg) + DIM_W'(1)) == cb;
    assign i_end = (DIM_W'(i_reg) + DIM_W'(1)) == ra;

    // request side
    assign req.ready = (state_reg == S_IDLE) && !op_valid_reg && !mac_busy;
    assign req_fire  = req.valid && req.ready;
    assign in_range  = ((IDX_W+1)'(req.row) < (IDX_W+1)'(MAX_DIM))
                    && ((IDX_W+1)'(req.col) < (IDX_W+1)'(MAX_DIM));
    assign waddr     = AW'(req.row) * AW'(MAX_DIM) + AW'(req.col);
    assign wr_a      = req_fire && in_range && (req.cmd == CMD_WRITE_A);
    assign wr_b      = req_fire && in_range && (req.cmd == CMD_WRITE_B);

    // pipeline moves when the response register can take a result
    assign adv      = !rsp_valid_reg || rsp.ready;
    assign issue    = (state_reg == S_RUN) && adv;
    assign err_load = (state_reg == S_ERR) && adv;

    assign addr_a = AW'(i_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign addr_b = AW'(k_reg) * AW'(MAX_DIM) + AW'(j_reg);

    assign issue_tag.first = (k_reg == '0);
    assign issue_tag.endk  = k_end;
    assign issue_tag.last  = k_end && j_end && i_end;
    assign issue_tag.i     = IDX_W'(i_reg);
    assign issue_tag.j     = IDX_W'(j_reg);

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mat_a[waddr] <= req.value;
        end
        if (wr_b)
        begin
            mat_b[waddr] <= req.value;
        end
        if (adv)
        begin
            rd_a_reg <= mat_a[addr_a];
            rd_b_reg <= mat_b[addr_b];
        end
    end

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= DIM_W'(8);
            cols_a_reg <= DIM_W'(8);
            rows_b_reg <= DIM_W'(8);
            cols_b_reg <= DIM_W'(8);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ROWS_A: rows_a_reg <= cfg.data;
                CFG_COLS_A: cols_a_reg <= cfg.data;
                CFG_ROWS_B: rows_b_reg <= cfg.data;
                CFG_COLS_B: cols_b_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // sequencer, issue stage and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            i_reg             <= '0;
            j_reg             <= '0;
            k_reg             <= '0;
            op_valid_reg      <= 1'b0;
            op_tag_reg        <= '0;
            rsp_valid_reg     <= 1'b0;
            out_row_reg       <= '0;
            out_col_reg       <= '0;
            product_value_reg <= '0;
            dim_error_reg     <= 1'b0;
            last_reg          <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                op_valid_reg <= issue;
                op_tag_reg   <= issue_tag;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire && (req.cmd == CMD_COMPUTE))
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                        k_reg <= '0;
                        if (cols_a_reg != rows_b_reg)
                        begin
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    if (adv)
                    begin
                        if (!k_end)
                        begin
                            k_reg <= k_reg + DW'(1);
                        end
                        else
                        begin
                            k_reg <= '0;
                            if (!j_end)
                            begin
                                j_reg <= j_reg + DW'(1);
                            end
                            else
                            begin
                                j_reg <= '0;
                                if (i_end)
                                begin
                                    state_reg <= S_IDLE;
                                end
                                else
                                begin
                                    i_reg <= i_reg + DW'(1);
                                end
                            end
                        end
                    end
                end
                S_ERR:
                begin
                    if (adv)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (mac_res_valid)
            begin
                rsp_valid_reg     <= 1'b1;
                out_row_reg       <= mac_res_tag.i;
                out_col_reg       <= mac_res_tag.j;
                product_value_reg <= mac_res_value;
                dim_error_reg     <= 1'b0;
                last_reg          <= mac_res_tag.last;
            end
            else if (err_load)
            begin
                rsp_valid_reg     <= 1'b1;
                out_row_reg       <= '0;
                out_col_reg       <= '0;
                product_value_reg <= '0;
                dim_error_reg     <= 1'b1;
                last_reg          <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    mm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .op_valid  (op_valid_reg),
        .op_tag    (op_tag_reg),
        .op_a      (rd_a_reg),
        .op_b      (rd_b_reg),
        .busy      (mac_busy),
        .res_valid (mac_res_valid),
        .res_tag   (mac_res_tag),
        .res_value (mac_res_value)
    );

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.out_row       = out_row_reg;
    assign rsp.out_col       = out_col_reg;
    assign rsp.product_value = product_value_reg;
    assign rsp.dim_error     = dim_error_reg;
    assign rsp.last          = last_reg;

endmodule

// ===== rtl/mm_checker.sv =====
// ----------------------------------------------------------------------------
// mm_checker
// Port-level checks for the matrix multiply block, bound to its top level.
// ----------------------------------------------------------------------------
module mm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  logic [1:0]                      req_cmd,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  logic [mm_pkg::IDX_W-1:0]        rsp_out_row,
    input  logic [mm_pkg::IDX_W-1:0]        rsp_out_col,
    input  logic signed [mm_pkg::PV_W-1:0]  rsp_product_value,
    input  logic                            rsp_dim_error,
    input  logic                            rsp_last
);
    import mm_pkg::*;

    // stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_product_value)
            && $stable(rsp_last) && $stable(rsp_dim_error))
        else $error("stalled response changed");

    // error response is a lone, zeroed, final response
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_dim_error |-> rsp_last && (rsp_product_value == '0)
            && (rsp_out_row == '0) && (rsp_out_col == '0))
        else $error("malformed dimension error response");

    // compute request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == CMD_COMPUTE) |=> !req_ready)
        else $error("request taken during compute");

    // after a non-final result the next one is up or the block is still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_last |=> rsp_valid || !req_ready)
        else $error("block idle before final result");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_cmd           (req.cmd),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_out_row       (rsp.out_row),
    .rsp_out_col       (rsp.out_col),
    .rsp_product_value (rsp.product_value),
    .rsp_dim_error     (rsp.dim_error),
    .rsp_last          (rsp.last)
);
